FILE: rtl/ksdv_pkg.sv
// ============================================================================
// ksdv_pkg
// Shared types and constants for the k-space density to velocity block.
// ============================================================================
package ksdv_pkg;

  localparam int IDX_W      = 10;
  localparam int DATA_W     = 32;
  localparam int GRID_W     = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int F_W        = 12;           // folded wavenumber, signed
  localparam int FMAG_W     = 11;           // its magnitude
  localparam int SQ_W       = 2 * FMAG_W;
  localparam int F2_W       = SQ_W + 2;     // sum of three squares
  localparam int PRE_W      = 2 * DATA_W;   // |delta| * inv_wave_step
  localparam int PART_W     = DATA_W + FMAG_W;
  localparam int NUM_W      = PRE_W + FMAG_W;
  localparam int FRAC_W     = 16;
  localparam int DIVIDEND_W = NUM_W - FRAC_W;
  localparam int Q_W        = 32;
  localparam int HI_W       = DIVIDEND_W - Q_W;
  localparam int DIV_STAGES = Q_W + 1;
  localparam int N_AXES     = 3;
  localparam int N_COMP     = 2 * N_AXES;

  localparam int MAX_GRID_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WAVE_STEP = 1'd1;

  localparam logic [GRID_W-1:0] GRID_RESET = 11'd256;
  localparam logic [DATA_W-1:0] INV_RESET  = 32'h0001_0000;

  localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [IDX_W-1:0]         x_index;
    logic [IDX_W-1:0]         y_index;
    logic [IDX_W-1:0]         z_index;
    logic signed [DATA_W-1:0] delta_re;
    logic signed [DATA_W-1:0] delta_im;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] vx_re;
    logic signed [DATA_W-1:0] vx_im;
    logic signed [DATA_W-1:0] vy_re;
    logic signed [DATA_W-1:0] vy_im;
    logic signed [DATA_W-1:0] vz_re;
    logic signed [DATA_W-1:0] vz_im;
  } out_t;

  // sideband that rides along the divider
  typedef struct packed {
    logic kill;
    logic neg;
  } tag_t;

endpackage

FILE: rtl/ksdv_div.sv
// ============================================================================
// ksdv_div
// Pipelined restoring divider: overflow check in the first stage, then one quotient bit per stage.
// ============================================================================
module ksdv_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [ksdv_pkg::DIVIDEND_W-1:0]      dividend,
  input  logic [ksdv_pkg::F2_W-1:0]            divisor,
  input  ksdv_pkg::tag_t                       in_tag,
  output logic                                 out_valid,
  output logic [ksdv_pkg::Q_W-1:0]             quotient,
  output logic                                 over,
  output ksdv_pkg::tag_t                       out_tag
);

  localparam int NS = ksdv_pkg::DIV_STAGES;

  logic                         vld  [NS];
  logic [ksdv_pkg::F2_W-1:0]    rem  [NS];
  logic [ksdv_pkg::F2_W-1:0]    dvs  [NS];
  logic [ksdv_pkg::Q_W-1:0]     low  [NS];
  logic [ksdv_pkg::Q_W-1:0]     quo  [NS];
  logic                         ovf  [NS];
  ksdv_pkg::tag_t               tag  [NS];

  // first stage: overflow check on the upper part
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    ovf[0] <= dividend[ksdv_pkg::DIVIDEND_W-1:ksdv_pkg::Q_W]
              >= ksdv_pkg::HI_W'(divisor);
    rem[0] <= dividend[ksdv_pkg::Q_W+ksdv_pkg::F2_W-1:ksdv_pkg::Q_W];
    low[0] <= dividend[ksdv_pkg::Q_W-1:0];
    dvs[0] <= divisor;
    quo[0] <= '0;
    tag[0] <= in_tag;
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    logic [ksdv_pkg::F2_W:0] trial;
    logic                    fits;
    assign trial = {rem[k-1], low[k-1][ksdv_pkg::Q_W-1]};
    assign fits  = trial >= {1'b0, dvs[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      rem[k] <= fits ? ksdv_pkg::F2_W'(trial - {1'b0, dvs[k-1]})
                     : trial[ksdv_pkg::F2_W-1:0];
      low[k] <= {low[k-1][ksdv_pkg::Q_W-2:0], 1'b0};
      quo[k] <= {quo[k-1][ksdv_pkg::Q_W-2:0], fits};
      dvs[k] <= dvs[k-1];
      ovf[k] <= ovf[k-1];
      tag[k] <= tag[k-1];
    end
  end

  assign out_valid = vld[NS-1];
  assign quotient  = quo[NS-1];
  assign over      = ovf[NS-1];
  assign out_tag   = tag[NS-1];

endmodule

FILE: rtl/kspace_density_to_velocity.sv
// ============================================================================
// kspace_density_to_velocity
// Velocity v = i*k/|k|^2 * delta * inv_wave_step for one Fourier grid cell.
// ============================================================================
// usage:
//   input word: item (x/y/z index, complex density) taken at an edge where
//   start is high and busy is low; busy is always low, so a new word can be
//   offered every cycle
//   output word: result, valid for exactly one cycle while done is high;
//   the receiver cannot stall, the pipeline never holds
//   throughput one word per cycle; the depth comes from the six pipelined
//   dividers (33 stages: an overflow check, then one quotient bit per
//   stage) plus fold, multiply, sum and saturate stages
//   config: cfg_we writes grid_size (index 0) or inv_wave_step (index 1);
//   write only while no word is in flight
//   reset: synchronous rst clears all valid bits and loads grid_size 256
//   and inv_wave_step 1.0
//   nyquist components and the zero wavenumber give zero outputs
// ============================================================================
module kspace_density_to_velocity #(
  parameter int MAX_GRID = ksdv_pkg::MAX_GRID_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  ksdv_pkg::in_t                      item,
  output logic                               done,
  output ksdv_pkg::out_t                     result,
  input  logic                               cfg_we,
  input  logic [ksdv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ksdv_pkg::DATA_W-1:0]        cfg_data
);

  localparam int NA  = ksdv_pkg::N_AXES;
  localparam int NC  = ksdv_pkg::N_COMP;
  localparam int LAT = 6 + ksdv_pkg::DIV_STAGES;

  // configuration registers
  logic [ksdv_pkg::GRID_W-1:0] grid_size;
  logic [ksdv_pkg::DATA_W-1:0] inv_wave_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size     <= ksdv_pkg::GRID_RESET;
      inv_wave_step <= ksdv_pkg::INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ksdv_pkg::REG_GRID_SIZE:     grid_size     <= cfg_data[ksdv_pkg::GRID_W-1:0];
        ksdv_pkg::REG_INV_WAVE_STEP: inv_wave_step <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // grid size clamped to the supported maximum
  logic [ksdv_pkg::GRID_W-1:0] n_eff;
  assign n_eff = (int'(grid_size) > MAX_GRID) ? ksdv_pkg::GRID_W'(MAX_GRID) : grid_size;

  // stage 1: capture the word
  logic                              v1;
  ksdv_pkg::in_t                     s1_item;
  logic [ksdv_pkg::GRID_W-1:0]       s1_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    s1_item <= item;
    s1_n    <= n_eff;
  end

  // stage 2: fold indices to signed wavenumbers, take magnitudes
  logic [ksdv_pkg::IDX_W-1:0]   raw  [NA];
  logic [ksdv_pkg::IDX_W-1:0]   half;
  logic                         v2;
  logic [ksdv_pkg::FMAG_W-1:0]  s2_fmag [NA];
  logic                         s2_fneg [NA];
  logic                         s2_nyq  [NA];
  logic [ksdv_pkg::DATA_W-1:0]  s2_dmag [2];   // 0: delta_im, 1: delta_re
  logic                         s2_dneg [2];

  assign raw[0] = s1_item.x_index;
  assign raw[1] = s1_item.y_index;
  assign raw[2] = s1_item.z_index;
  assign half   = s1_n[ksdv_pkg::GRID_W-1:1];

  always_ff @(posedge clk) begin
    logic signed [ksdv_pkg::F_W-1:0] f;
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int a = 0; a < NA; a++) begin
      f = $signed({2'b00, raw[a]});
      if (raw[a] >= half) begin
        f = f - $signed({1'b0, s1_n});
      end
      s2_fneg[a] <= f[ksdv_pkg::F_W-1];
      s2_fmag[a] <= f[ksdv_pkg::F_W-1] ? ksdv_pkg::FMAG_W'(-f) : ksdv_pkg::FMAG_W'(f);
      s2_nyq[a]  <= raw[a] == half;
    end
    s2_dneg[0] <= s1_item.delta_im[ksdv_pkg::DATA_W-1];
    s2_dneg[1] <= s1_item.delta_re[ksdv_pkg::DATA_W-1];
    s2_dmag[0] <= s1_item.delta_im[ksdv_pkg::DATA_W-1]
                  ? ksdv_pkg::DATA_W'(-s1_item.delta_im) : s1_item.delta_im;
    s2_dmag[1] <= s1_item.delta_re[ksdv_pkg::DATA_W-1]
                  ? ksdv_pkg::DATA_W'(-s1_item.delta_re) : s1_item.delta_re;
  end

  // stage 3: squares and |delta| * inv_wave_step
  logic                          v3;
  logic [ksdv_pkg::SQ_W-1:0]     s3_sq   [NA];
  logic [ksdv_pkg::FMAG_W-1:0]   s3_fmag [NA];
  logic                          s3_fneg [NA];
  logic                          s3_nyq  [NA];
  logic [ksdv_pkg::PRE_W-1:0]    s3_pre  [2];
  logic                          s3_dneg [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int a = 0; a < NA; a++) begin
      s3_sq[a]   <= s2_fmag[a] * s2_fmag[a];
      s3_fmag[a] <= s2_fmag[a];
      s3_fneg[a] <= s2_fneg[a];
      s3_nyq[a]  <= s2_nyq[a];
    end
    for (int r = 0; r < 2; r++) begin
      s3_pre[r]  <= ksdv_pkg::PRE_W'(s2_dmag[r]) * ksdv_pkg::PRE_W'(inv_wave_step);
      s3_dneg[r] <= s2_dneg[r];
    end
  end

  // stage 4: |f|^2 and partial products by |f_axis|
  // component c: axis c/2; even c is the real part (from delta_im, negated)
  logic                          v4;
  logic [ksdv_pkg::F2_W-1:0]     s4_f2;
  logic [ksdv_pkg::PART_W-1:0]   s4_plo [NC];
  logic [ksdv_pkg::PART_W-1:0]   s4_phi [NC];
  logic                          s4_neg [NC];
  logic                          s4_nyq [NA];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4_f2 <= ksdv_pkg::F2_W'(s3_sq[0]) + ksdv_pkg::F2_W'(s3_sq[1])
           + ksdv_pkg::F2_W'(s3_sq[2]);
    for (int c = 0; c < NC; c++) begin
      s4_plo[c] <= ksdv_pkg::PART_W'(s3_pre[c % 2][ksdv_pkg::DATA_W-1:0])
                   * ksdv_pkg::PART_W'(s3_fmag[c / 2]);
      s4_phi[c] <= ksdv_pkg::PART_W'(s3_pre[c % 2][ksdv_pkg::PRE_W-1:ksdv_pkg::DATA_W])
                   * ksdv_pkg::PART_W'(s3_fmag[c / 2]);
      s4_neg[c] <= ((c % 2) == 0) ^ s3_fneg[c / 2] ^ s3_dneg[c % 2];
    end
    for (int a = 0; a < NA; a++) begin
      s4_nyq[a] <= s3_nyq[a];
    end
  end

  // stage 5: full product, drop the fraction, mark killed components
  logic                              v5;
  logic [ksdv_pkg::F2_W-1:0]         s5_f2;
  logic [ksdv_pkg::DIVIDEND_W-1:0]   s5_m   [NC];
  ksdv_pkg::tag_t                    s5_tag [NC];

  always_ff @(posedge clk) begin
    logic [ksdv_pkg::NUM_W-1:0] num;
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    s5_f2 <= s4_f2;
    for (int c = 0; c < NC; c++) begin
      num = (ksdv_pkg::NUM_W'(s4_phi[c]) << ksdv_pkg::DATA_W)
          + ksdv_pkg::NUM_W'(s4_plo[c]);
      s5_m[c]        <= num[ksdv_pkg::NUM_W-1:ksdv_pkg::FRAC_W];
      s5_tag[c].neg  <= s4_neg[c];
      s5_tag[c].kill <= s4_nyq[c / 2] || (s4_f2 == '0);
    end
  end

  // six dividers by |f|^2
  logic                      dv_valid [NC];
  logic [ksdv_pkg::Q_W-1:0]  dv_q     [NC];
  logic                      dv_over  [NC];
  ksdv_pkg::tag_t            dv_tag   [NC];

  for (genvar c = 0; c < NC; c++) begin : g_div
    ksdv_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v5),
      .dividend  (s5_m[c]),
      .divisor   (s5_f2),
      .in_tag    (s5_tag[c]),
      .out_valid (dv_valid[c]),
      .quotient  (dv_q[c]),
      .over      (dv_over[c]),
      .out_tag   (dv_tag[c])
    );
  end

  // output stage: sign, saturate, zero the killed components
  logic [ksdv_pkg::Q_W-1:0] comp [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      if (dv_tag[c].kill) begin
        comp[c] = '0;
      end else if (dv_tag[c].neg) begin
        comp[c] = (dv_over[c] || dv_q[c] > ksdv_pkg::SAT_NEG) ? ksdv_pkg::SAT_NEG
                                                              : -dv_q[c];
      end else begin
        comp[c] = (dv_over[c] || dv_q[c][ksdv_pkg::Q_W-1]) ? ksdv_pkg::SAT_POS
                                                           : dv_q[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[0];
    end
    result.vx_re <= comp[0];
    result.vx_im <= comp[1];
    result.vy_re <= comp[2];
    result.vy_im <= comp[3];
    result.vz_re <= comp[4];
    result.vz_im <= comp[5];
  end

  // every result traces back to an earlier accepted word
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without an accepted word");

  // the zero wavenumber cell always gives an all-zero result
  a_dc_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && item.x_index == '0 && item.y_index == '0
                   && item.z_index == '0, LAT)) |-> (result == '0))
    else $error("nonzero velocity at zero wavenumber");

endmodule
